@@ rtl/core/orf_pkg.sv @@
// shared types, constants and crc helper for the occupancy report framer
`timescale 1ns / 1ps
package orf_pkg;

	localparam int CHANNELS         = 4;
	localparam int WINDOW_TICKS_DEF = 4;
	localparam int SMP_W            = 12;
	localparam int CNT_W            = $clog2(CHANNELS + 1);

	// frame layout
	localparam int FRAME_LEN  = 19;
	localparam int IDX_W      = $clog2(FRAME_LEN);
	localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(FRAME_LEN - 1);
	localparam logic [IDX_W-1:0] CRC_END_IDX = IDX_W'(FRAME_LEN - 3);
	localparam logic [7:0] SYNC_0   = 8'hC5;
	localparam logic [7:0] SYNC_1   = 8'h5C;
	localparam logic [7:0] BODY_LEN = 8'd14;

	// crc-16/modbus
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_OVER  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPEAT    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GATEWAY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OWN       = 3'd4;

	// reset values of the registers
	localparam logic [SMP_W-1:0] THRESHOLD_RST = 12'd2200;
	localparam logic [2:0]       MIN_OVER_RST  = 3'd1;
	localparam logic [7:0]       REPEAT_RST    = 8'd3;
	localparam logic [15:0]      GATEWAY_RST   = 16'h0102;
	localparam logic [15:0]      OWN_RST       = 16'h0000;

	typedef logic [CHANNELS-1:0][SMP_W-1:0] smp_arr_t;

	typedef struct packed {
		logic [SMP_W-1:0] threshold;
		logic [2:0]       min_chan;
		logic [7:0]       repeat_windows;
		logic [15:0]      gateway;
		logic [15:0]      own;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		smp_arr_t   smp;
		logic       occ;
		logic [7:0] seq;
	} frame_req_t;

	// one byte through the reflected crc, bit by bit
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

@@ rtl/core/orf_lane.sv @@
// one channel lane: compares its sample against the occupancy threshold
`timescale 1ns / 1ps
module orf_lane (
	input  logic [orf_pkg::SMP_W-1:0] sample,
	input  logic [orf_pkg::SMP_W-1:0] threshold,
	output logic                      over
);
	import orf_pkg::*;

	// strictly above the threshold counts
	assign over = (sample > threshold);

endmodule

@@ rtl/core/orf_merge.sv @@
// merges lane results, tracks the window and decides when a frame goes out
`timescale 1ns / 1ps
module orf_merge #(
	parameter int WINDOW_TICKS = orf_pkg::WINDOW_TICKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic [orf_pkg::CHANNELS-1:0]  over,
	input  orf_pkg::smp_arr_t             smp,
	input  logic                          provisioned,
	input  orf_pkg::cfg_t                 cfg,
	output orf_pkg::frame_req_t           req
);
	import orf_pkg::*;

	localparam int TW = (WINDOW_TICKS > 1) ? $clog2(WINDOW_TICKS) : 1;
	localparam logic [TW-1:0] TICK_LAST = TW'(WINDOW_TICKS - 1);

	logic [TW-1:0] tick_q;
	logic          any_occ_q;
	logic [1:0]    last_sent_q;
	logic [7:0]    same_cnt_q;
	logic [7:0]    seq_q;

	logic [CNT_W-1:0] lanes_over;
	logic             tick_occ;
	logic             win_close;
	logic             win_occ;
	logic             changed;
	logic [7:0]       same_inc;
	logic             repeat_hit;
	logic             send;

	// count of lanes over threshold
	always_comb begin
		lanes_over = '0;
		for (int i = 0; i < CHANNELS; i++) begin
			lanes_over = lanes_over + CNT_W'(over[i]);
		end
	end

	assign tick_occ   = ({{(8-CNT_W){1'b0}}, lanes_over} >= {5'd0, cfg.min_chan});
	assign win_close  = (tick_q == TICK_LAST);
	assign win_occ    = any_occ_q | tick_occ;
	assign changed    = ({1'b0, win_occ} != last_sent_q);
	assign same_inc   = same_cnt_q + 8'd1;
	assign repeat_hit = (same_inc >= cfg.repeat_windows);
	assign send       = win_close & provisioned & (changed | repeat_hit);

	// request towards the framer
	assign req.valid = accept & send;
	assign req.smp   = smp;
	assign req.occ   = win_occ;
	assign req.seq   = seq_q;

	// window and send state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q      <= '0;
			any_occ_q   <= 1'b0;
			last_sent_q <= 2'd3;
			same_cnt_q  <= '0;
			seq_q       <= '0;
		end else if (accept) begin
			if (win_close) begin
				tick_q    <= '0;
				any_occ_q <= 1'b0;
				if (provisioned) begin
					if (changed) begin
						last_sent_q <= {1'b0, win_occ};
						same_cnt_q  <= '0;
					end else if (repeat_hit) begin
						same_cnt_q <= '0;
					end else begin
						same_cnt_q <= same_inc;
					end
				end
			end else begin
				tick_q    <= tick_q + TW'(1);
				any_occ_q <= win_occ;
			end
			if (send) begin
				seq_q <= seq_q + 8'd1;
			end
		end
	end

endmodule

@@ rtl/core/orf_framer.sv @@
// frame serialiser: one waiting request plus the byte-per-cycle output with crc, held while out_stall is high
`timescale 1ns / 1ps
module orf_framer (
	input  logic                clk,
	input  logic                arst_n,
	input  orf_pkg::frame_req_t req,
	input  orf_pkg::cfg_t       cfg,
	output logic                busy_full,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          frame_byte,
	output logic                last_byte
);
	import orf_pkg::*;

	frame_req_t       pend_q;
	logic             pend_vld_q;
	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      crc_q;
	smp_arr_t         smp_q;
	logic             occ_q;
	logic [7:0]       seq_q;

	logic out_acc;
	logic is_last;
	logic load;

	assign out_valid = active_q;
	assign is_last   = (idx_q == LAST_IDX);
	assign last_byte = is_last;
	assign out_acc   = active_q & ~out_stall;
	assign load      = pend_vld_q & (~active_q | (out_acc & is_last));
	// the slot frees in the cycle the serialiser picks it up
	assign busy_full = pend_vld_q & ~load;

	// byte select by position in the frame
	always_comb begin
		case (idx_q)
			5'd0:    frame_byte = SYNC_0;
			5'd1:    frame_byte = SYNC_1;
			5'd2:    frame_byte = BODY_LEN;
			5'd3:    frame_byte = cfg.gateway[7:0];
			5'd4:    frame_byte = cfg.gateway[15:8];
			5'd5:    frame_byte = cfg.own[7:0];
			5'd6:    frame_byte = cfg.own[15:8];
			5'd7:    frame_byte = smp_q[0][7:0];
			5'd8:    frame_byte = {4'd0, smp_q[0][11:8]};
			5'd9:    frame_byte = smp_q[1][7:0];
			5'd10:   frame_byte = {4'd0, smp_q[1][11:8]};
			5'd11:   frame_byte = smp_q[2][7:0];
			5'd12:   frame_byte = {4'd0, smp_q[2][11:8]};
			5'd13:   frame_byte = smp_q[3][7:0];
			5'd14:   frame_byte = {4'd0, smp_q[3][11:8]};
			5'd15:   frame_byte = {7'd0, occ_q};
			5'd16:   frame_byte = seq_q;
			5'd17:   frame_byte = crc_q[7:0];
			default: frame_byte = crc_q[15:8];
		endcase
	end

	// waiting request slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_vld_q <= 1'b0;
		end else if (req.valid) begin
			pend_vld_q <= 1'b1;
		end else if (load) begin
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid) begin
			pend_q <= req;
		end
	end

	// output sequencing and running crc
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (out_acc) begin
			if (is_last) begin
				active_q <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			smp_q <= pend_q.smp;
			occ_q <= pend_q.occ;
			seq_q <= pend_q.seq;
			crc_q <= CRC_INIT;
		end else if (out_acc && idx_q <= CRC_END_IDX) begin
			crc_q <= crc_byte(crc_q, frame_byte);
		end
	end

endmodule

@@ rtl/core/occupancy_report_framer_top.sv @@
// top level of the occupancy report framer: lanes, window merge and frame serialiser
//
// Input channel: in_valid / in_stall carry one report tick word (four 12-bit
// samples and the provisioned flag). A word is taken when in_valid is high and
// in_stall low. Every WINDOW_TICKS words close a window; a closing word may
// start a 19-byte report frame.
// Output channel: out_valid / out_stall carry one frame byte per word, with
// last_byte on the final crc byte. A frame streams at one byte per cycle when
// not stalled; the request of the window-closing word is registered in the
// request slot, then loaded into the serialiser, which presents the first byte.
// Input words are taken every cycle while frames stream out; in_stall rises
// only when a second frame waits in the single request slot behind the one
// being sent, and drops in the cycle the serialiser picks it up.
// Stalling the output holds the current byte; the crc advances per byte taken.
// Configuration: cfg_we writes cfg_data into register cfg_index at the clock edge;
// write it only while the block is idle. Unknown indexes are ignored.
// Reset (arst_n low) restores register defaults, clears the window counters,
// the sequence number and any pending or partly sent frame.
`timescale 1ns / 1ps
module occupancy_report_framer_top #(
	parameter int WINDOW_TICKS = orf_pkg::WINDOW_TICKS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [orf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [orf_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [orf_pkg::SMP_W-1:0]       sample_a,
	input  logic [orf_pkg::SMP_W-1:0]       sample_b,
	input  logic [orf_pkg::SMP_W-1:0]       sample_c,
	input  logic [orf_pkg::SMP_W-1:0]       sample_d,
	input  logic                            provisioned,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      frame_byte,
	output logic                            last_byte
);
	import orf_pkg::*;

	cfg_t                cfg_q;
	smp_arr_t            smp;
	logic [CHANNELS-1:0] over;
	logic                accept;
	frame_req_t          req;
	logic                busy_full;

	assign smp      = {sample_d, sample_c, sample_b, sample_a};
	assign in_stall = busy_full;
	assign accept   = in_valid & ~in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold      <= THRESHOLD_RST;
			cfg_q.min_chan       <= MIN_OVER_RST;
			cfg_q.repeat_windows <= REPEAT_RST;
			cfg_q.gateway        <= GATEWAY_RST;
			cfg_q.own            <= OWN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold      <= cfg_data[SMP_W-1:0];
				REG_MIN_OVER:  cfg_q.min_chan       <= cfg_data[2:0];
				REG_REPEAT:    cfg_q.repeat_windows <= cfg_data[7:0];
				REG_GATEWAY:   cfg_q.gateway        <= cfg_data;
				REG_OWN:       cfg_q.own            <= cfg_data;
				default: ;
			endcase
		end
	end

	// one compare lane per channel
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		orf_lane u_lane (
			.sample    (smp[g]),
			.threshold (cfg_q.threshold),
			.over      (over[g])
		);
	end

	orf_merge #(
		.WINDOW_TICKS (WINDOW_TICKS)
	) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.over        (over),
		.smp         (smp),
		.provisioned (provisioned),
		.cfg         (cfg_q),
		.req         (req)
	);

	orf_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg        (cfg_q),
		.busy_full  (busy_full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.frame_byte (frame_byte),
		.last_byte  (last_byte)
	);

endmodule

@@ rtl/core/orf_checker.sv @@
// port-level checker for the occupancy report framer, bound to the top level
`timescale 1ns / 1ps
module orf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] frame_byte,
	input logic       last_byte
);
	import orf_pkg::*;

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_byte) && $stable(last_byte))
		else $error("stalled output word changed");

	// after a last byte the next word is never a last byte
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_byte |=> !last_byte)
		else $error("two last bytes in a row");

	// a frame that follows directly opens with the first sync byte
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last_byte |=> !out_valid || frame_byte == SYNC_0)
		else $error("frame does not start with sync byte");

	// input stall with an idle output is resolved in the next cycle
	a_stall_drains: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_valid |=> out_valid)
		else $error("input stalled while serialiser idle");

endmodule

bind occupancy_report_framer_top orf_checker u_orf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.frame_byte (frame_byte),
	.last_byte  (last_byte)
);

@@ verif/tb_occupancy_report_framer_top.sv @@
// self-checking bench for the occupancy report framer: tick words in, frame bytes checked out
`timescale 1ns / 1ps
module tb_occupancy_report_framer_top;
	import orf_pkg::*;

	localparam int LIMIT_CYCLES  = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 250;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;
	typedef enum logic [1:0] {ANY_DECISION, NO_FRAME, FRAME_OCC0, FRAME_OCC1} decision_t;

	typedef struct packed {
		smp_arr_t smp;
		logic     prov;
	} tick_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_word_t;

	typedef struct packed {
		row_kind_t                kind;
		tick_t                    tick;
		decision_t                want;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    data;
	} row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_stall;
	logic [SMP_W-1:0]       sample_a;
	logic [SMP_W-1:0]       sample_b;
	logic [SMP_W-1:0]       sample_c;
	logic [SMP_W-1:0]       sample_d;
	logic                   provisioned;
	logic                   out_valid;
	logic                   out_stall;
	logic [7:0]             frame_byte;
	logic                   last_byte;

	// occupancy model state and its copy of the registers
	cfg_t        model_cfg;
	int          win_tick;
	logic [2:0]  occ_ticks;
	logic [1:0]  last_state;
	logic [7:0]  same_windows;
	logic [7:0]  seq_num;

	frame_word_t expected_bytes[$];
	row_t        plan[$];

	int  cycle;
	int  errors;
	int  ticks_sent;
	int  cfg_writes;
	int  bytes_checked;
	int  frames_checked;
	int  max_in_stall;
	int  hold_req;
	int  hold_seen;
	int  hold_left;
	int  burst_left;
	bit  calm;

	occupancy_report_framer_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample_a    (sample_a),
		.sample_b    (sample_b),
		.sample_c    (sample_c),
		.sample_d    (sample_d),
		.provisioned (provisioned),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.frame_byte  (frame_byte),
		.last_byte   (last_byte)
	);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic note_error(input string what, input int want, input int got);
		errors++;
		if (errors <= 10) begin
			$display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h", cycle, what, want, got);
		end
	endtask

	function automatic logic [15:0] modbus_crc16(input logic [7:0] msg [FRAME_LEN], input int len);
		logic [15:0] acc;
		acc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			acc = acc ^ {8'h00, msg[i]};
			for (int b = 0; b < 8; b++) begin
				if (acc[0]) begin
					acc = (acc >> 1) ^ CRC_POLY;
				end else begin
					acc = acc >> 1;
				end
			end
		end
		return acc;
	endfunction

	// window tally, send decision and frame build for one taken tick word
	task automatic occupancy_tick(input tick_t t, output logic sent, output logic occ);
		logic [7:0]  msg [FRAME_LEN];
		logic [15:0] crc;
		int          over;
		over = 0;
		sent = 1'b0;
		occ  = 1'b0;
		for (int i = 0; i < CHANNELS; i++) begin
			if (t.smp[i] > model_cfg.threshold) over++;
		end
		if (over >= model_cfg.min_chan && occ_ticks < 3'd7) occ_ticks++;
		win_tick++;
		if (win_tick < WINDOW_TICKS_DEF) return;

		// window closes here
		occ = (occ_ticks != 3'd0);
		occ_ticks = '0;
		win_tick = 0;
		if (t.prov) begin
			if ({1'b0, occ} != last_state) begin
				last_state = {1'b0, occ};
				same_windows = '0;
				sent = 1'b1;
			end else begin
				same_windows++;
				if (same_windows >= model_cfg.repeat_windows) begin
					same_windows = '0;
					sent = 1'b1;
				end
			end
		end
		if (!sent) return;

		msg[0] = SYNC_0;
		msg[1] = SYNC_1;
		msg[2] = BODY_LEN;
		msg[3] = model_cfg.gateway[7:0];
		msg[4] = model_cfg.gateway[15:8];
		msg[5] = model_cfg.own[7:0];
		msg[6] = model_cfg.own[15:8];
		for (int i = 0; i < CHANNELS; i++) begin
			msg[7 + 2 * i] = t.smp[i][7:0];
			msg[8 + 2 * i] = {4'h0, t.smp[i][SMP_W-1:8]};
		end
		msg[15] = {7'd0, occ};
		msg[16] = seq_num;
		crc = modbus_crc16(msg, FRAME_LEN - 2);
		msg[17] = crc[7:0];
		msg[18] = crc[15:8];
		for (int i = 0; i < FRAME_LEN; i++) begin
			expected_bytes.push_back(frame_word_t'{data: msg[i], last: (i == FRAME_LEN - 1)});
		end
		seq_num++;
	endtask

	// register write and model update; the caller lowers cfg_we later
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_THRESHOLD: model_cfg.threshold = data[SMP_W-1:0];
			REG_MIN_OVER:  model_cfg.min_chan = data[2:0];
			REG_REPEAT:    model_cfg.repeat_windows = data[7:0];
			REG_GATEWAY:   model_cfg.gateway = data;
			REG_OWN:       model_cfg.own = data;
			default: ;
		endcase
		cfg_writes++;
	endtask

	// offer one tick word, optionally after an idle burst, and wait for it to be taken
	task automatic put_tick(input tick_t t, input bit may_idle, output logic sent, output logic occ);
		int gap;
		int stalled;
		stalled = 0;
		cfg_we <= 1'b0;
		if (may_idle && !calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sample_a    <= t.smp[0];
		sample_b    <= t.smp[1];
		sample_c    <= t.smp[2];
		sample_d    <= t.smp[3];
		provisioned <= t.prov;
		@(posedge clk);
		while (in_stall) begin
			stalled++;
			@(posedge clk);
		end
		if (stalled > max_in_stall) max_in_stall = stalled;
		ticks_sent++;
		occupancy_tick(t, sent, occ);
	endtask

	// let every expected byte come out, then idle for a quiet settle period
	task automatic drain();
		in_valid <= 1'b0;
		cfg_we   <= 1'b0;
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic row_t mk_tick(input logic [SMP_W-1:0] a, input logic [SMP_W-1:0] b,
			input logic [SMP_W-1:0] c, input logic [SMP_W-1:0] d, input logic prov,
			input decision_t want);
		row_t r;
		r.kind      = ROW_TICK;
		r.tick.smp  = {d, c, b, a};
		r.tick.prov = prov;
		r.want      = want;
		r.idx       = '0;
		r.data      = '0;
		return r;
	endfunction

	function automatic row_t mk_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		row_t r;
		r.kind      = ROW_CFG;
		r.tick.smp  = '0;
		r.tick.prov = 1'b0;
		r.want      = ANY_DECISION;
		r.idx       = idx;
		r.data      = data;
		return r;
	endfunction

	// samples clustered on the threshold, the rails and anywhere
	function automatic logic [SMP_W-1:0] pick_sample(input logic [SMP_W-1:0] thr);
		case ($urandom_range(0, 5))
			0:       return '0;
			1:       return '1;
			2:       return thr;
			3:       return thr + 1'b1;
			4:       return thr - 1'b1;
			default: return SMP_W'($urandom);
		endcase
	endfunction

	function automatic tick_t random_tick();
		tick_t t;
		bit    quiet;
		quiet = ($urandom_range(0, 3) == 0);
		for (int i = 0; i < CHANNELS; i++) begin
			if (quiet) begin
				t.smp[i] = SMP_W'($urandom_range(0, model_cfg.threshold));
			end else begin
				t.smp[i] = pick_sample(model_cfg.threshold);
			end
		end
		t.prov = ($urandom_range(0, 7) != 0);
		return t;
	endfunction

	// one register setting per phase, junk in the unused upper bits
	task automatic random_config(input int p);
		logic [CFG_DATA_W-1:0] thr;
		logic [2:0]            need_chan;
		logic [7:0]            rep;
		thr = CFG_DATA_W'($urandom);
		if (p == 0) thr[SMP_W-1:0] = '0;
		if (p == 1) thr[SMP_W-1:0] = '1;
		need_chan = (p == 0) ? 3'd4 : (p == 1) ? 3'd0 : 3'($urandom_range(0, 5));
		rep = (p == 2) ? 8'd255 : (p == 3) ? 8'd1 : 8'($urandom_range(0, 4));
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_MIN_OVER, {13'($urandom), need_chan});
		write_reg(REG_REPEAT, {8'($urandom), rep});
		write_reg(REG_GATEWAY, (p == 1) ? 16'h0000 : CFG_DATA_W'($urandom));
		write_reg(REG_OWN, (p == 1) ? 16'h0000 : CFG_DATA_W'($urandom));
		write_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), CFG_DATA_W'($urandom));
	endtask

	// receiver: random stall bursts, plus one long hold on request
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (burst_left > 0) begin
			burst_left--;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			burst_left = $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each taken output word with the oldest expected frame byte
	always @(posedge clk) begin : byte_check
		frame_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_bytes.size() == 0) begin
				note_error("unexpected frame byte", 0, {last_byte, frame_byte});
			end else begin
				want = expected_bytes.pop_front();
				if (frame_byte !== want.data) note_error("frame_byte", want.data, frame_byte);
				if (last_byte !== want.last) note_error("last_byte", want.last, last_byte);
				bytes_checked++;
				if (want.last) frames_checked++;
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycle++;
		if (cycle >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d bytes still expected", cycle, expected_bytes.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : main_seq
		logic      sent;
		logic      occ;
		decision_t got;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		in_valid    = 1'b0;
		sample_a    = '0;
		sample_b    = '0;
		sample_c    = '0;
		sample_d    = '0;
		provisioned = 1'b0;
		out_stall   = 1'b0;
		calm        = 1'b0;

		// model back to its reset state
		model_cfg.threshold      = THRESHOLD_RST;
		model_cfg.min_chan       = MIN_OVER_RST;
		model_cfg.repeat_windows = REPEAT_RST;
		model_cfg.gateway        = GATEWAY_RST;
		model_cfg.own            = OWN_RST;
		win_tick     = 0;
		occ_ticks    = '0;
		last_state   = 2'd3;
		same_windows = '0;
		seq_num      = '0;

		// first window after reset always sends
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, FRAME_OCC0));
		// samples equal to the threshold do not count; unchanged state held back
		plan.push_back(mk_tick(12'd2200, 12'd2200, 12'd2200, 12'd2200, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd2200, 12'd2200, 12'd2200, 12'd2200, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd2200, 12'd2200, 12'd2200, 12'd2200, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd2200, 12'd2200, 12'd2200, 12'd2200, 1'b1, NO_FRAME));
		// occupied window while not provisioned: no frame
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd2201, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_FRAME));
		// zero channels needed: every tick counts as occupied
		plan.push_back(mk_cfg(REG_MIN_OVER, 16'h0000));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, FRAME_OCC1));
		// more channels than exist, zero repeat, address rails, unknown index
		plan.push_back(mk_cfg(REG_MIN_OVER, 16'hFFFF));
		plan.push_back(mk_cfg(REG_REPEAT, 16'hFF00));
		plan.push_back(mk_cfg(REG_GATEWAY, 16'hFFFF));
		plan.push_back(mk_cfg(REG_OWN, 16'hFFFF));
		plan.push_back(mk_cfg(REG_THRESHOLD, 16'hF000));
		plan.push_back(mk_cfg(REG_SPARE_LO, 16'hFFFF));
		plan.push_back(mk_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, FRAME_OCC0));
		plan.push_back(mk_tick(12'hAAA, 12'h555, 12'hAAA, 12'h555, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'h555, 12'hAAA, 12'h555, 12'hAAA, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'h0F0, 12'hF0F, 12'h00F, 12'hFF0, 1'b1, ANY_DECISION));
		plan.push_back(mk_tick(12'h123, 12'h456, 12'h789, 12'hABC, 1'b1, FRAME_OCC0));

		// reset
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (i == 0 || plan[i-1].kind == ROW_TICK) drain();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				put_tick(plan[i].tick, 1'b1, sent, occ);
				got = sent ? (occ ? FRAME_OCC1 : FRAME_OCC0) : NO_FRAME;
				if (plan[i].want != ANY_DECISION && got != plan[i].want) begin
					note_error("window decision", plan[i].want, got);
				end
			end
		end

		// random phases, one register setting each
		for (int p = 0; p < 6; p++) begin
			drain();
			random_config(p);
			repeat (21) put_tick(random_tick(), 1'b1, sent, occ);
		end

		// back-pressure: a frame every provisioned window while the receiver holds off
		drain();
		write_reg(REG_REPEAT, 16'h0000);
		write_reg(REG_MIN_OVER, 16'h0001);
		hold_req++;
		repeat (30) put_tick(random_tick(), 1'b0, sent, occ);

		// closing stretch with no idling on either side
		drain();
		calm = 1'b1;
		write_reg(REG_REPEAT, 16'h0001);
		write_reg(REG_THRESHOLD, CFG_DATA_W'($urandom));
		repeat (30) put_tick(random_tick(), 1'b0, sent, occ);
		drain();

		$display("%0d tick words over %0d register writes; %0d frames (%0d bytes) compared",
			ticks_sent, cfg_writes, frames_checked, bytes_checked);
		$display("longest input stall %0d cycles, %0d mismatches", max_in_stall, errors);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ occupancy_report_framer_top.f @@
rtl/core/orf_pkg.sv
rtl/core/orf_lane.sv
rtl/core/orf_merge.sv
rtl/core/orf_framer.sv
rtl/core/occupancy_report_framer_top.sv
rtl/core/orf_checker.sv
verif/tb_occupancy_report_framer_top.sv
